>>> hdl/assert_macros.svh
// Assertion macros shared by the eviction block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check with reset disable.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication check with reset disable.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> hdl/bdoe_pkg.sv
// Package: opcodes, sequencer states and fixed widths for the eviction block.
package bdoe_pkg;
    localparam int IdW    = 64;
    localparam int FrameW = 64;
    localparam int BytesW = 29;
    localparam int TotalW = 40;
    localparam int CountW = 7;
    localparam logic [BytesW-1:0] MaxAssetBytes = 29'(1 << 28);
    localparam logic [CountW-1:0] CountMax = 7'd127;

    typedef enum logic [1:0] {
        OP_UPLOAD  = 2'd0,
        OP_PUBLISH = 2'd1,
        OP_TOUCH   = 2'd2,
        OP_EVICT   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_EV_SCAN,
        ST_EV_DROP,
        ST_DONE
    } state_t;
endpackage

>>> hdl/budget_driven_oldest_first_eviction.sv
// Top level: resident-asset table with oldest-first eviction under a byte budget.
// Upload/touch scan every slot, then apply; publish goes straight to the result; evict is
// skipped when within budget or history is short, else k slot scans (k = d or d+1 for d drops).
// Throughput: one transaction at a time; the next is taken only once the result has left the output.
// The slot RAM read port (one slot per cycle) sets the rate.
// Reset clears valid bits, the total and the frame at once; no clearing pass.
`include "assert_macros.svh"
module budget_driven_oldest_first_eviction #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic        asset_kind,
    input  logic [63:0] asset_id,
    input  logic [28:0] byte_count,
    input  logic [63:0] frame_number,
    input  logic [63:0] retention_frames,
    input  logic [39:0] budget_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        entry_found,
    output logic        table_full,
    output logic [6:0]  evicted_count,
    output logic [39:0] resident_total
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam int SumW = bdoe_pkg::TotalW + 1;
    localparam int RecW = 1 + bdoe_pkg::IdW + bdoe_pkg::FrameW + bdoe_pkg::BytesW;

    bdoe_pkg::state_t state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [SumW-1:0] sum_reg, sum_next;
    logic [bdoe_pkg::FrameW-1:0] frame_reg, frame_next;
    logic [1:0] op_reg, op_next;
    logic kind_reg, kind_next;
    logic [63:0] id_reg, id_next;
    logic [28:0] bytes_reg, bytes_next;
    logic [63:0] cutoff_reg, cutoff_next;
    logic [39:0] budget_reg, budget_next;
    logic [CW-1:0] cnt_reg, cnt_next;        // issue index, one ahead of data
    logic [AW-1:0] didx_reg, didx_next;      // index of data now on the read port
    logic dv_reg, dv_next;
    logic hit_reg, hit_next;
    logic [AW-1:0] hidx_reg, hidx_next;
    logic [bdoe_pkg::BytesW-1:0] hbytes_reg, hbytes_next;
    logic freef_reg, freef_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [63:0] best_lu_reg, best_lu_next;
    logic [6:0] drop_reg, drop_next;
    logic ov_valid_reg, ov_valid_next;
    logic o_found_reg, o_found_next, o_full_reg, o_full_next;
    logic [6:0] o_cnt_reg, o_cnt_next;
    logic [63:0] r_lu_keep_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [RecW-1:0] wdata, rdata;
    logic r_kind;
    logic [63:0] r_id, r_lu;
    logic [28:0] r_bytes;

    assign {r_kind, r_id, r_lu, r_bytes} = rdata;

    bdoe_ram #(.WIDTH(RecW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_stall = (state_reg != bdoe_pkg::ST_IDLE) || ov_valid_reg;
    assign out_valid = ov_valid_reg;
    assign entry_found = o_found_reg;
    assign table_full = o_full_reg;
    assign evicted_count = o_cnt_reg;
    assign resident_total = sum_reg[SumW-1] ? {40{1'b1}} : sum_reg[39:0];
    assign raddr = cnt_reg[AW-1:0];

    wire accept = in_valid && !in_stall;
    wire dvalid = dv_reg && valid_reg[didx_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdoe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (bdoe_pkg::opcode_t'(opcode))
                        bdoe_pkg::OP_PUBLISH: state_next = bdoe_pkg::ST_DONE;
                        bdoe_pkg::OP_EVICT:   state_next = bdoe_pkg::ST_EV_SCAN;
                        default:              state_next = bdoe_pkg::ST_SCAN;
                    endcase
                end
            end
            bdoe_pkg::ST_SCAN:
                if (!dv_reg && cnt_reg == CW'(TABLE_ENTRIES)) state_next = bdoe_pkg::ST_APPLY;
            bdoe_pkg::ST_APPLY:   state_next = bdoe_pkg::ST_DONE;
            bdoe_pkg::ST_EV_SCAN:
                if (!dv_reg && cnt_reg == CW'(TABLE_ENTRIES)) state_next = bdoe_pkg::ST_EV_DROP;
            bdoe_pkg::ST_EV_DROP:
                state_next = (hit_reg && (sum_reg - SumW'(hbytes_reg)) > SumW'(budget_reg))
                             ? bdoe_pkg::ST_EV_SCAN : bdoe_pkg::ST_DONE;
            bdoe_pkg::ST_DONE:    state_next = bdoe_pkg::ST_IDLE;
            default:              state_next = bdoe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        sum_next = sum_reg;
        frame_next = frame_reg;
        op_next = op_reg;
        kind_next = kind_reg;
        id_next = id_reg;
        bytes_next = bytes_reg;
        cutoff_next = cutoff_reg;
        budget_next = budget_reg;
        cnt_next = cnt_reg;
        didx_next = didx_reg;
        dv_next = 1'b0;
        hit_next = hit_reg;
        hidx_next = hidx_reg;
        hbytes_next = hbytes_reg;
        freef_next = freef_reg;
        fidx_next = fidx_reg;
        best_lu_next = best_lu_reg;
        drop_next = drop_reg;
        ov_valid_next = ov_valid_reg && out_stall;
        o_found_next = o_found_reg;
        o_full_next = o_full_reg;
        o_cnt_next = o_cnt_reg;
        we = 1'b0;
        waddr = hidx_reg;
        wdata = {kind_reg, id_reg, 64'd0, bytes_reg};
        unique case (state_reg)
            bdoe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = opcode;
                    kind_next = asset_kind;
                    id_next = asset_id;
                    bytes_next = (byte_count > bdoe_pkg::MaxAssetBytes)
                                 ? bdoe_pkg::MaxAssetBytes : byte_count;
                    cutoff_next = frame_reg - retention_frames;
                    budget_next = budget_bytes;
                    cnt_next = '0;
                    hit_next = 1'b0;
                    freef_next = 1'b0;
                    drop_next = '0;
                    if (opcode == bdoe_pkg::OP_PUBLISH) frame_next = frame_number;
                    // skip eviction when within budget or history too short
                    if (opcode == bdoe_pkg::OP_EVICT &&
                        (sum_reg <= SumW'(budget_bytes) || frame_reg < retention_frames))
                        cnt_next = CW'(TABLE_ENTRIES);
                end
            end
            bdoe_pkg::ST_SCAN, bdoe_pkg::ST_EV_SCAN:
            begin
                if (cnt_reg != CW'(TABLE_ENTRIES))
                begin
                    dv_next = 1'b1;
                    didx_next = cnt_reg[AW-1:0];
                    cnt_next = cnt_reg + 1'b1;
                end
                if (state_reg == bdoe_pkg::ST_SCAN)
                begin
                    if (dvalid && !hit_reg && r_kind == kind_reg && r_id == id_reg)
                    begin
                        hit_next = 1'b1;
                        hidx_next = didx_reg;
                        hbytes_next = r_bytes;
                    end
                    if (dv_reg && !valid_reg[didx_reg] && !freef_reg)
                    begin
                        freef_next = 1'b1;
                        fidx_next = didx_reg;
                    end
                end
                else if (dvalid && r_lu < cutoff_reg && (!hit_reg || r_lu < best_lu_reg))
                begin
                    hit_next = 1'b1;
                    hidx_next = didx_reg;
                    hbytes_next = r_bytes;
                    best_lu_next = r_lu;
                end
            end
            bdoe_pkg::ST_APPLY:
            begin
                o_found_next = 1'b0;
                o_full_next = 1'b0;
                o_cnt_next = '0;
                if (op_reg == bdoe_pkg::OP_UPLOAD)
                begin
                    if (hit_reg)
                    begin
                        o_found_next = 1'b1;
                        sum_next = sum_reg - SumW'(hbytes_reg) + SumW'(bytes_reg);
                        we = 1'b1;
                        wdata = {kind_reg, id_reg, r_lu_keep_reg, bytes_reg};
                    end
                    else if (freef_reg)
                    begin
                        we = 1'b1;
                        waddr = fidx_reg;
                        valid_next[fidx_reg] = 1'b1;
                        sum_next = sum_reg + SumW'(bytes_reg);
                    end
                    else
                    begin
                        o_full_next = 1'b1;
                    end
                end
                else if (hit_reg)
                begin
                    o_found_next = 1'b1;
                    we = 1'b1;
                    wdata = {kind_reg, id_reg, frame_reg, hbytes_reg};
                end
            end
            bdoe_pkg::ST_EV_DROP:
            begin
                cnt_next = '0;
                if (hit_reg)
                begin
                    valid_next[hidx_reg] = 1'b0;
                    sum_next = sum_reg - SumW'(hbytes_reg);
                    if (drop_reg != bdoe_pkg::CountMax) drop_next = drop_reg + 1'b1;
                end
                hit_next = 1'b0;
            end
            bdoe_pkg::ST_DONE:
            begin
                ov_valid_next = 1'b1;
                if (op_reg == bdoe_pkg::OP_EVICT)
                begin
                    o_found_next = 1'b0;
                    o_full_next = 1'b0;
                    o_cnt_next = drop_reg;
                end
                else if (op_reg == bdoe_pkg::OP_PUBLISH)
                begin
                    o_found_next = 1'b0;
                    o_full_next = 1'b0;
                    o_cnt_next = '0;
                end
            end
            default: ;
        endcase
    end

    // keep last-use of the matched slot for a resize
    always_ff @(posedge clk)
    begin
        if (state_reg == bdoe_pkg::ST_SCAN && dvalid && !hit_reg &&
            r_kind == kind_reg && r_id == id_reg)
        begin
            r_lu_keep_reg <= r_lu;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdoe_pkg::ST_IDLE;
            valid_reg <= '0;
            sum_reg <= '0;
            frame_reg <= '0;
            dv_reg <= 1'b0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            sum_reg <= sum_next;
            frame_reg <= frame_next;
            dv_reg <= dv_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        kind_reg <= kind_next;
        id_reg <= id_next;
        bytes_reg <= bytes_next;
        cutoff_reg <= cutoff_next;
        budget_reg <= budget_next;
        cnt_reg <= cnt_next;
        didx_reg <= didx_next;
        hit_reg <= hit_next;
        hidx_reg <= hidx_next;
        hbytes_reg <= hbytes_next;
        freef_reg <= freef_next;
        fidx_reg <= fidx_next;
        best_lu_reg <= best_lu_next;
        drop_reg <= drop_next;
        o_found_reg <= o_found_next;
        o_full_reg <= o_full_next;
        o_cnt_reg <= o_cnt_next;
    end

    `CHK_IMPL(a_stall_busy, clk, rst_n, state_reg != bdoe_pkg::ST_IDLE, in_stall)
    `CHK_NEXT(a_done_out, clk, rst_n, state_reg == bdoe_pkg::ST_DONE, out_valid)
    `CHK_IMPL(a_full_flag, clk, rst_n, out_valid && table_full,
              !entry_found && evicted_count == 7'd0)
endmodule

>>> hdl/bdoe_ram.sv
// Generic single-port-write RAM with one registered read port.
module bdoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> tb/tb.sv
// Testbench for the resident-asset table with oldest-first eviction under a byte budget.
`timescale 1ns / 100ps
module tb;
    localparam int SLOTS = 64;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  op;
        logic        kind;
        logic [63:0] id;
        logic [28:0] bytes;
        logic [63:0] frame;
        logic [63:0] retain;
        logic [39:0] budget;
    } asset_req_t;

    typedef struct packed {
        logic        found;
        logic        full;
        logic [6:0]  count;
        logic [39:0] total;
    } table_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic        asset_kind;
    logic [63:0] asset_id;
    logic [28:0] byte_count;
    logic [63:0] frame_number;
    logic [63:0] retention_frames;
    logic [39:0] budget_bytes;
    logic        out_valid;
    logic        out_stall;
    logic        entry_found;
    logic        table_full;
    logic [6:0]  evicted_count;
    logic [39:0] resident_total;

    budget_driven_oldest_first_eviction u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .asset_kind(asset_kind), .asset_id(asset_id),
        .byte_count(byte_count), .frame_number(frame_number),
        .retention_frames(retention_frames), .budget_bytes(budget_bytes),
        .out_valid(out_valid), .out_stall(out_stall),
        .entry_found(entry_found), .table_full(table_full),
        .evicted_count(evicted_count), .resident_total(resident_total)
    );

    // predictor state
    logic        mdl_valid [SLOTS];
    logic        mdl_kind  [SLOTS];
    logic [63:0] mdl_id    [SLOTS];
    logic [63:0] mdl_used  [SLOTS];
    logic [28:0] mdl_bytes [SLOTS];
    logic [63:0] mdl_sum;
    logic [63:0] mdl_frame;

    asset_req_t pending_reqs[$];
    table_rsp_t expected_rsps[$];
    int  errors = 0;
    int  sent = 0;
    int  got = 0;
    int  n_evicted = 0;
    int  n_full = 0;
    bit  quiet_tail = 0;
    bit  stim_done = 0;
    int  hold_off = 300;
    int  idle_cycles = 0;
    int  drv_gap = 0;
    int  mon_gap = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void enqueue_req(asset_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic int lookup_slot(logic kind, logic [63:0] id);
        for (int s = 0; s < SLOTS; s++)
            if (mdl_valid[s] && mdl_kind[s] == kind && mdl_id[s] == id)
                return s;
        return -1;
    endfunction

    function automatic table_rsp_t apply_request(asset_req_t r);
        table_rsp_t  o;
        int          s;
        int          best;
        int          dropped;
        logic [63:0] sz;
        logic [63:0] cutoff;
        o = '0;
        sz = (r.bytes > bdoe_pkg::MaxAssetBytes) ? 64'(bdoe_pkg::MaxAssetBytes)
                                                 : 64'(r.bytes);
        case (bdoe_pkg::opcode_t'(r.op))
            bdoe_pkg::OP_UPLOAD:
            begin
                s = lookup_slot(r.kind, r.id);
                if (s >= 0)
                begin
                    o.found = 1'b1;
                    mdl_sum = mdl_sum - mdl_bytes[s] + sz;
                    mdl_bytes[s] = sz[28:0];
                end
                else
                begin
                    s = -1;
                    for (int k = SLOTS - 1; k >= 0; k--)
                        if (!mdl_valid[k]) s = k;
                    if (s < 0)
                        o.full = 1'b1;
                    else
                    begin
                        mdl_valid[s] = 1'b1;
                        mdl_kind[s] = r.kind;
                        mdl_id[s] = r.id;
                        mdl_used[s] = '0;
                        mdl_bytes[s] = sz[28:0];
                        mdl_sum = mdl_sum + sz;
                    end
                end
            end
            bdoe_pkg::OP_PUBLISH: mdl_frame = r.frame;
            bdoe_pkg::OP_TOUCH:
            begin
                s = lookup_slot(r.kind, r.id);
                if (s >= 0)
                begin
                    o.found = 1'b1;
                    mdl_used[s] = mdl_frame;
                end
            end
            default:
            begin
                dropped = 0;
                if (mdl_sum > 64'(r.budget) && mdl_frame >= r.retain)
                begin
                    cutoff = mdl_frame - r.retain;
                    while (mdl_sum > 64'(r.budget))
                    begin
                        best = -1;
                        for (int k = 0; k < SLOTS; k++)
                            if (mdl_valid[k] && mdl_used[k] < cutoff &&
                                (best < 0 || mdl_used[k] < mdl_used[best]))
                                best = k;
                        if (best < 0) break;
                        mdl_sum = mdl_sum - mdl_bytes[best];
                        mdl_valid[best] = 1'b0;
                        dropped++;
                    end
                end
                o.count = (dropped > 127) ? bdoe_pkg::CountMax : 7'(dropped);
            end
        endcase
        o.total = (mdl_sum > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : mdl_sum[39:0];
        return o;
    endfunction

    function automatic asset_req_t make_req(logic [1:0] op, logic kind, logic [63:0] id,
                                            logic [28:0] bytes, logic [63:0] frame,
                                            logic [63:0] retain, logic [39:0] budget);
        asset_req_t r;
        r = '{op, kind, id, bytes, frame, retain, budget};
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            asset_kind <= 1'b0;
            asset_id <= '0;
            byte_count <= '0;
            frame_number <= '0;
            retention_frames <= '0;
            budget_bytes <= '0;
            drv_gap <= 0;
        end
        else
        begin
            if (stim_done && pending_reqs.size() < 60) quiet_tail <= 1'b1;
            if (in_valid && !in_stall)
            begin
                expected_rsps.insert(expected_rsps.size(),
                    apply_request({opcode, asset_kind, asset_id, byte_count,
                                   frame_number, retention_frames, budget_bytes}));
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap <= drv_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 15) == 0)
                begin
                    drv_gap <= $urandom_range(1, 17) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    asset_req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    opcode <= r.op;
                    asset_kind <= r.kind;
                    asset_id <= r.id;
                    byte_count <= r.bytes;
                    frame_number <= r.frame;
                    retention_frames <= r.retain;
                    budget_bytes <= r.budget;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mon_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                table_rsp_t e;
                got++;
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result");
                    errors++;
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (entry_found !== e.found)
                    begin
                        $error("entry_found exp %0h got %0h", e.found, entry_found);
                        errors++;
                    end
                    if (table_full !== e.full)
                    begin
                        $error("table_full exp %0h got %0h", e.full, table_full);
                        errors++;
                    end
                    if (evicted_count !== e.count)
                    begin
                        $error("evicted_count exp %0d got %0d", e.count, evicted_count);
                        errors++;
                    end
                    if (resident_total !== e.total)
                    begin
                        $error("resident_total exp %0h got %0h", e.total, resident_total);
                        errors++;
                    end
                    if (e.count != 0) n_evicted++;
                    if (e.full) n_full++;
                end
            end
            // long hold-off first, then random stall bursts
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end
            else if (mon_gap > 0)
            begin
                mon_gap <= mon_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                mon_gap <= $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] ids [8];
        logic [63:0] frame_now;
        int          n;
        rst_n = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            mdl_valid[s] = 1'b0;
            mdl_kind[s] = 1'b0;
            mdl_id[s] = '0;
            mdl_used[s] = '0;
            mdl_bytes[s] = '0;
        end
        mdl_sum = '0;
        mdl_frame = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-table evict, touch miss, extremes, resize, saturation
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_TOUCH, 1'b1, '1, 29'd0, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_UPLOAD, 1'b0, 64'd0, '1, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_UPLOAD, 1'b1, '1, 29'h1000_0000,
                             64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_UPLOAD, 1'b1, 64'd0, 29'h1000_0001,
                             64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_UPLOAD, 1'b0, 64'd0, 29'd5, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_TOUCH, 1'b1, '1, 29'd0, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_PUBLISH, 1'b0, 64'd0, 29'd0, 64'd10, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_TOUCH, 1'b1, 64'd0, 29'd0, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, 64'd20, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, 64'd0, '1));
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_PUBLISH, 1'b0, 64'd0, 29'd0, '1, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, '1, 40'd0));
        // fill the table to force the full flag
        for (int k = 0; k < SLOTS + 2; k++)
            enqueue_req(make_req(bdoe_pkg::OP_UPLOAD, k[0], 64'(k) + 100,
                                 29'(k * 1000), 64'd0, 64'd0, 40'd0));
        enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'b0, 64'd0, 29'd0, 64'd0, 64'd0, 40'd0));

        // random: frame-by-frame sessions over a small id pool so hits and evictions occur
        for (int k = 0; k < 8; k++) ids[k] = rand64();
        frame_now = 64'd10;
        n = 0;
        while (n < 420)
        begin
            frame_now = frame_now + $urandom_range(1, 3);
            enqueue_req(make_req(bdoe_pkg::OP_PUBLISH, 1'($urandom), rand64(),
                                 29'($urandom), frame_now, rand64(), 40'(rand64())));
            for (int j = $urandom_range(2, 10); j > 0; j--)
            begin
                logic [63:0] id;
                logic [1:0]  op;
                id = ($urandom_range(0, 3) == 0) ? rand64() :
                     {ids[$urandom_range(0, 7)][63:6], 6'($urandom_range(0, 15))};
                op = ($urandom_range(0, 1) != 0) ? bdoe_pkg::OP_UPLOAD : bdoe_pkg::OP_TOUCH;
                if ($urandom_range(0, 19) == 0) op = 2'($urandom_range(0, 3));
                enqueue_req(make_req(op, 1'($urandom), id,
                    ($urandom_range(0, 9) == 0) ? 29'($urandom) : 29'($urandom_range(0, 1 << 22)),
                    ($urandom_range(0, 19) == 0) ? rand64() : frame_now,
                    rand64(), 40'(rand64())));
                n++;
            end
            enqueue_req(make_req(bdoe_pkg::OP_EVICT, 1'($urandom), rand64(), 29'($urandom),
                rand64(), 64'($urandom_range(0, 4)),
                ($urandom_range(0, 7) == 0) ? 40'(rand64()) : 40'($urandom_range(0, 1 << 26))));
            n += 2;
        end
        stim_done = 1'b1;

        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (40 * SLOTS) @(posedge clk);
        $display("Ran %0d transactions through the table and checked %0d results.", sent, got);
        $display("Evictions that dropped entries: %0d; uploads refused by a full table: %0d.",
                 n_evicted, n_full);
        if (errors == 0 && expected_rsps.size() == 0 && got == sent)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
